### sv/line_follow_pid_steer_assert.svh
// Assertion macros for the line follower steering block.
// Included by the top level; empty when SYNTHESIS is defined.
`ifndef LINE_FOLLOW_PID_STEER_ASSERT_SVH
`define LINE_FOLLOW_PID_STEER_ASSERT_SVH
`ifndef SYNTHESIS
`define LFPS_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define LFPS_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define LFPS_ASSERT_IMP(label, clk, rst, a, c, msg)
`define LFPS_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

### sv/lfps_pkg.sv
// Shared types and constants of the line follower steering block.
// No dependencies.
`default_nettype none
package lfps_pkg;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_KP = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KI = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KD = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CRUISE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPIN = 3'd6;

  localparam logic [1:0] MODE_TRACK = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_LEFT = 2'd2;
  localparam logic [1:0] MODE_HOLD = 2'd3;

  localparam logic [1:0] TURN_NONE = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT = 2'd2;

  localparam logic [15:0] LOST_POSITION = 16'd65280;
  localparam int DRIVE_LIMIT = 200;
  localparam logic [15:0] LEFT_LOW_Q = 16'd13312;
  localparam logic [15:0] LEFT_HIGH_Q = 16'd17920;
  localparam logic [15:0] RIGHT_HIGH_Q = 16'd5120;
  localparam int STEPS = 100;

  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quotient;
    logic [6:0]  remainder;
  } div_rsp_t;
endpackage
`default_nettype wire

### sv/lfps_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lfps_pkg.
`default_nettype none
module lfps_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lfps_pkg::div_req_t req,
  output lfps_pkg::div_rsp_t      rsp
);
  import lfps_pkg::*;

  logic [23:0] quo;
  logic [7:0]  rem;
  logic [6:0]  dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [7:0]  trial;

  assign trial = {rem[6:0], quo[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'd24;
        quo <= req.dividend;
        dsr <= req.divisor;
        rem <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[22:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem[6:0];
endmodule
`default_nettype wire

### sv/line_follow_pid_steer.sv
// Line follower steering: one frame of sensor samples in, one drive result out.
// A tracked frame goes through an accept state, a sensor scan over all sensors,
// one pass through the divider for the position (start and result), one state
// for the error magnitude, four steps on one shared 18x23 multiplier (integral
// step by reciprocal, then the three PID terms), clamp, drive mix, and a result
// state held until taken. A frame with the line lost goes from the scan and the
// position state straight to the result state. Not ready while busy.
// Depends on lfps_pkg, lfps_div and line_follow_pid_steer_assert.svh.
`default_nettype none
`include "line_follow_pid_steer_assert.svh"
module line_follow_pid_steer #(
  parameter int SENSOR_COUNT = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [lfps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [lfps_pkg::CFG_BITS-1:0]       cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // sample_0 .. sample_{N-1}, SAMPLE_BITS each, from the lowest bit up
  input  wire logic [((SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // left_drive[8:0], right_drive[17:9], mode_status[19:18],
  // line_position[35:20], track_error[50:36], control_value[67:51]
  output logic [71:0]                              m_tdata
);
  import lfps_pkg::*;

  localparam int CNT_BITS = $clog2(SENSOR_COUNT + 1);
  localparam int IDX_BITS = $clog2(SENSOR_COUNT);
  localparam int RECIP_STEPS = 5243;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_POS, S_POSW, S_ERR, S_INT,
    S_MP, S_MI, S_MD, S_OUT, S_DRV, S_SEND
  } state_t;

  state_t state;
  logic signed [15:0] kp_gain, ki_gain, kd_gain;
  logic [14:0] target_position;
  logic [9:0]  detect_threshold;
  logic [7:0]  cruise_speed, spin_speed;

  logic signed [17:0] error_integral;
  logic signed [14:0] previous_error;
  logic [1:0]         turn_memory;
  logic signed [8:0]  held_left, held_right;

  logic [SENSOR_COUNT*SAMPLE_BITS-1:0] frame;
  logic [IDX_BITS-1:0] idx;
  logic [CNT_BITS-1:0] count;
  logic [15:0] wsum;
  logic [15:0] pos;
  logic signed [14:0] err;
  logic [14:0] mag;
  logic signed [16:0] ctl;
  logic [1:0] mode;
  logic signed [40:0] acc;
  logic signed [17:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [40:0] prod;

  div_req_t dreq;
  div_rsp_t drsp;

  lfps_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [SAMPLE_BITS-1:0] cur;
  logic signed [17:0] bound;
  logic signed [16:0] pos_s, tgt_s, diff;
  logic signed [17:0] inc, isum;
  logic signed [41:0] rsum;
  logic signed [33:0] fl;
  logic signed [16:0] t;
  logic signed [9:0] lsum, rsub;
  logic [7:0] spin_c;

  assign cur = frame[idx*SAMPLE_BITS +: SAMPLE_BITS];
  assign bound = $signed({2'b0, cruise_speed, 8'b0});
  assign pos_s = $signed({1'b0, drsp.quotient[15:0]});
  assign tgt_s = $signed({2'b0, target_position});
  assign diff = tgt_s - pos_s;
  assign inc = err[14] ? -$signed({3'b0, prod[33:19]})
                       : $signed({3'b0, prod[33:19]});
  assign isum = error_integral + inc;
  assign prod = mul_a * mul_b;
  assign rsum = {acc[40], acc} + 42'sd128;
  assign fl = rsum[41:8];
  assign t = ctl[16] ? -((-ctl) >>> 8) : (ctl >>> 8);
  assign lsum = $signed({2'b0, cruise_speed}) + t[9:0];
  assign rsub = $signed({2'b0, cruise_speed}) - t[9:0];
  assign spin_c = (spin_speed > 8'(DRIVE_LIMIT)) ? 8'(DRIVE_LIMIT) : spin_speed;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_INT: begin
        mul_a = 18'(mag) + 18'(STEPS / 2);
        mul_b = 23'(RECIP_STEPS);
      end
      S_MP: begin
        mul_a = 18'(kp_gain);
        mul_b = 23'(err);
      end
      S_MI: begin
        mul_a = 18'(ki_gain);
        mul_b = 23'(error_integral);
      end
      S_MD: begin
        mul_a = 18'(kd_gain);
        mul_b = 23'(16'(err) - 16'(previous_error)) * 23'sd100;
      end
      default: ;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = '0;
    dreq.divisor = '0;
    case (state)
      S_POS: begin
        dreq.start = 1'b1;
        dreq.dividend = {wsum, 8'b0};
        dreq.divisor = 7'(count);
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_SEND);
  assign m_tdata = {4'b0, ctl, err, pos, mode, held_right, held_left};

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= 16'sd640;
      ki_gain <= '0;
      kd_gain <= 16'sd128;
      target_position <= 15'd8960;
      detect_threshold <= 10'd900;
      cruise_speed <= 8'd100;
      spin_speed <= 8'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP: kp_gain <= cfg_data;
        REG_KI: ki_gain <= cfg_data;
        REG_KD: kd_gain <= cfg_data;
        REG_TARGET: target_position <= cfg_data[14:0];
        REG_THRESH: detect_threshold <= cfg_data[9:0];
        REG_CRUISE: cruise_speed <= cfg_data[7:0];
        REG_SPIN: spin_speed <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      error_integral <= '0;
      previous_error <= '0;
      turn_memory <= TURN_NONE;
      held_left <= '0;
      held_right <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            frame <= s_tdata[SENSOR_COUNT*SAMPLE_BITS-1:0];
            idx <= '0;
            count <= '0;
            wsum <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (32'(cur) > 32'(detect_threshold)) begin
            wsum <= wsum + 16'(10 * (SENSOR_COUNT - 1)) - 16'(10 * idx);
            count <= count + 1'b1;
          end
          if (32'(idx) == SENSOR_COUNT - 1) state <= S_POS;
          else idx <= idx + 1'b1;
        end
        S_POS: begin
          if (count == '0) begin
            pos <= LOST_POSITION;
            err <= '0;
            ctl <= '0;
            error_integral <= '0;
            previous_error <= '0;
            if (turn_memory == TURN_RIGHT) begin
              held_left <= $signed({1'b0, spin_c});
              held_right <= -$signed({1'b0, spin_c});
              mode <= MODE_RIGHT;
            end else if (turn_memory == TURN_LEFT) begin
              held_left <= -$signed({1'b0, spin_c});
              held_right <= $signed({1'b0, spin_c});
              mode <= MODE_LEFT;
            end else begin
              mode <= MODE_HOLD;
            end
            state <= S_SEND;
          end else begin
            state <= S_POSW;
          end
        end
        S_POSW: begin
          if (drsp.done) begin
            pos <= drsp.quotient[15:0];
            if (drsp.quotient[15:0] > LEFT_LOW_Q && drsp.quotient[15:0] <= LEFT_HIGH_Q)
              turn_memory <= TURN_LEFT;
            else if (drsp.quotient[15:0] < RIGHT_HIGH_Q)
              turn_memory <= TURN_RIGHT;
            if (diff > 17'sd16383) err <= 15'sd16383;
            else if (diff < -17'sd16384) err <= -15'sd16384;
            else err <= diff[14:0];
            state <= S_ERR;
          end
        end
        S_ERR: begin
          mag <= err[14] ? 15'(-err) : 15'(err);
          state <= S_INT;
        end
        S_INT: begin
          if (isum > bound) error_integral <= bound;
          else if (isum < -bound) error_integral <= -bound;
          else error_integral <= isum;
          state <= S_MP;
        end
        S_MP: begin
          acc <= prod;
          state <= S_MI;
        end
        S_MI: begin
          acc <= acc + prod;
          state <= S_MD;
        end
        S_MD: begin
          acc <= acc + prod;
          previous_error <= err;
          state <= S_OUT;
        end
        S_OUT: begin
          if (fl > 34'(bound)) ctl <= bound[16:0];
          else if (fl < -34'(bound)) ctl <= 17'(-bound);
          else ctl <= fl[16:0];
          state <= S_DRV;
        end
        S_DRV: begin
          if (lsum > 10'sd200) held_left <= 9'sd200;
          else if (lsum < -10'sd200) held_left <= -9'sd200;
          else held_left <= lsum[8:0];
          if (rsub > 10'sd200) held_right <= 9'sd200;
          else if (rsub < -10'sd200) held_right <= -9'sd200;
          else held_right <= rsub[8:0];
          mode <= MODE_TRACK;
          state <= S_SEND;
        end
        S_SEND: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LFPS_ASSERT_IMP(a_excl, clk, rst, m_tvalid, !s_tready, "ready while result pending")
  `LFPS_ASSERT_IMP(a_drv, clk, rst, m_tvalid, (held_left <= 9'sd200) && (held_left >= -9'sd200), "left drive out of range")
  `LFPS_ASSERT_NXT(a_take, clk, rst, s_tvalid && s_tready, state == S_SCAN, "accept did not start scan")
endmodule
`default_nettype wire
